// ===== hdl/u2l_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2l_pkg: shared types and helpers of the utf-8 text sanitizer
// Holds the command passed from the decoder to the serializer and the
// functions that filter code points and build output bytes.
// ----------------------------------------------------------------------------
package u2l_pkg;

    localparam int CP_W    = 21;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int IDX_W   = 4;

    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_LOWER_U   = 8'h75;
    localparam logic [7:0] BYTE_UPPER_U   = 8'h55;

    // one kept code point on its way to the serializer
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            latin1;
    } u2l_cmd_t;

    // controls and DEL / C1 controls are dropped, TAB and LF kept
    function automatic logic cp_keep(logic [CP_W-1:0] cp);
        logic drop;
        drop = (cp < 21'h20 && cp != 21'h09 && cp != 21'h0A) ||
               (cp >= 21'h7F && cp < 21'hA0);
        return !drop;
    endfunction

    // number of output bytes for one command
    function automatic logic [IDX_W-1:0] cmd_len(u2l_cmd_t c);
        logic [IDX_W-1:0] n;
        if (c.latin1) begin
            if (c.cp <= 21'hFF)         n = 4'd1;
            else if (c.cp < 21'h10000)  n = 4'd6;
            else                        n = 4'd10;
        end else begin
            if (c.cp < 21'h80)          n = 4'd1;
            else if (c.cp < 21'h800)    n = 4'd2;
            else if (c.cp < 21'h10000)  n = 4'd3;
            else                        n = 4'd4;
        end
        return n;
    endfunction

    // lowercase hex digit
    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
        else             r = 8'h57 + {4'd0, nib};
        return r;
    endfunction

    // output byte number idx of one command
    function automatic logic [7:0] cmd_byte(u2l_cmd_t c, logic [IDX_W-1:0] idx);
        logic [31:0]      cpx;
        logic [IDX_W-1:0] nib_idx;
        logic [3:0]       nib;
        logic [7:0]       r;
        cpx     = {11'd0, c.cp};
        nib_idx = (c.cp < 21'h10000) ? (4'd5 - idx) : (4'd9 - idx);
        nib     = 4'(cpx >> {nib_idx[2:0], 2'b00});
        r       = 8'h00;
        if (c.latin1) begin
            if (c.cp <= 21'hFF) begin
                r = c.cp[7:0];
            end else if (idx == 4'd0) begin
                r = BYTE_BACKSLASH;
            end else if (idx == 4'd1) begin
                r = (c.cp < 21'h10000) ? BYTE_LOWER_U : BYTE_UPPER_U;
            end else begin
                r = hex_char(nib);
            end
        end else begin
            if (c.cp < 21'h80) begin
                r = c.cp[7:0];
            end else if (c.cp < 21'h800) begin
                r = (idx == 4'd0) ? {3'b110, c.cp[10:6]} : {2'b10, c.cp[5:0]};
            end else if (c.cp < 21'h10000) begin
                case (idx)
                    4'd0:    r = {4'b1110, c.cp[15:12]};
                    4'd1:    r = {2'b10, c.cp[11:6]};
                    default: r = {2'b10, c.cp[5:0]};
                endcase
            end else begin
                case (idx)
                    4'd0:    r = {5'b11110, c.cp[20:18]};
                    4'd1:    r = {2'b10, c.cp[17:12]};
                    4'd2:    r = {2'b10, c.cp[11:6]};
                    default: r = {2'b10, c.cp[5:0]};
                endcase
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/u2l_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2l_front: utf-8 decoder and filter
// Accepts one input byte per cycle while the queue has room, gathers code
// points, folds CR / LF and queues every kept code point as a command.
// ----------------------------------------------------------------------------
module u2l_front import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       latin1_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       q_full,
    output logic       q_push,
    output u2l_cmd_t   q_push_cmd
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic            after_cr_reg, after_cr_next;
    logic [CP_W-1:0] cp;
    logic            take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    // decode one byte
    always_comb begin
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        after_cr_next = after_cr_reg;
        cp            = '0;
        q_push        = 1'b0;
        if (take) begin
            after_cr_next = 1'b0;
            if (s_in_byte >= 8'h80 && s_in_byte <= 8'hBF) begin
                if (rem_reg != 2'd0) begin
                    acc_next = {acc_reg[CP_W-7:0], s_in_byte[5:0]};
                    rem_next = rem_reg - 2'd1;
                    if (rem_reg == 2'd1) begin
                        cp       = acc_next;
                        q_push   = cp_keep(acc_next);
                        acc_next = '0;
                    end
                end
            end else begin
                rem_next = 2'd0;
                acc_next = '0;
                if (s_in_byte == BYTE_CR) begin
                    cp            = {13'd0, BYTE_LF};
                    q_push        = 1'b1;
                    after_cr_next = 1'b1;
                end else if (s_in_byte == BYTE_LF && after_cr_reg) begin
                    // LF of a CR LF pair is swallowed
                end else if (s_in_byte < 8'h80) begin
                    cp     = {13'd0, s_in_byte};
                    q_push = cp_keep(cp);
                end else if (s_in_byte <= 8'hDF) begin
                    acc_next = {16'd0, s_in_byte[4:0]};
                    rem_next = 2'd1;
                end else if (s_in_byte <= 8'hEF) begin
                    acc_next = {17'd0, s_in_byte[3:0]};
                    rem_next = 2'd2;
                end else if (s_in_byte <= 8'hF7) begin
                    acc_next = {18'd0, s_in_byte[2:0]};
                    rem_next = 2'd3;
                end
            end
        end
    end

    assign q_push_cmd = '{cp: cp, latin1: latin1_mode};

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            rem_reg      <= 2'd0;
            after_cr_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            after_cr_reg <= after_cr_next;
        end
    end

endmodule

// ===== hdl/u2l_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2l_fifo: command queue
// Short show-ahead queue between the decoder and the serializer.
// ----------------------------------------------------------------------------
module u2l_fifo import u2l_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  u2l_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output u2l_cmd_t head_cmd
);

    u2l_cmd_t           mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/u2l_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2l_back: output serializer
// Takes one command at a time and sends its bytes through a registered
// output stage, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module u2l_back import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  u2l_cmd_t   q_cmd,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_in_run
);

    u2l_cmd_t         cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             advance, is_last;

    assign advance = cur_valid_reg && (!m_valid_reg || m_ready);
    assign is_last = (idx_reg == cmd_len(cur_reg) - 4'd1);
    assign q_pop   = q_valid && (!cur_valid_reg || (advance && is_last));

    // byte sequencing and command load
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (advance) begin
            byte_next    = cmd_byte(cur_reg, idx_reg);
            last_next    = is_last;
            m_valid_next = 1'b1;
            idx_next     = is_last ? '0 : idx_reg + 4'd1;
            if (is_last) cur_valid_next = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_in_run = last_reg;

endmodule

// ===== hdl/utf8_to_latin1_text_sanitizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_latin1_text_sanitizer: utf-8 text cleaner
// Decodes a utf-8 byte stream, drops control characters, folds CR LF and
// writes Latin-1 with hex escapes or utf-8 again.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid / s_ready / s_in_byte carry one input byte per item.
//   m_valid / m_ready / m_out_byte / m_last_in_run carry one output byte;
//   m_last_in_run marks the last byte caused by one input byte.
//   cfg_valid / cfg_ready / cfg_latin1_mode write the mode register
//   (1 = Latin-1 with \u / \U escapes, 0 = utf-8); write only while idle.
// Timing:
//   an input byte is taken every cycle while the 4-entry command queue
//   has room; a code point passes through the queue, the serializer's
//   command register and the output byte register before its first output
//   byte is valid. The serializer sends one byte per cycle while m_ready
//   allows, so a code point costs 1 to 10 output bytes (10 for a \U
//   escape), and input stalls only when the queue is full.
// Reset:
//   aresetn low clears decoder state, queue and output valid; the mode
//   returns to Latin-1. A stalled receiver holds the output byte and
//   backs up through the queue into s_ready.
// ----------------------------------------------------------------------------
module utf8_to_latin1_text_sanitizer import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_latin1_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_in_run
);

    logic     latin1_mode_reg, latin1_mode_next;
    logic     q_push, q_full, q_pop, q_valid;
    u2l_cmd_t q_push_cmd, q_head_cmd;

    // mode register
    assign cfg_ready        = 1'b1;
    assign latin1_mode_next = cfg_valid ? cfg_latin1_mode : latin1_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latin1_mode_reg <= 1'b1;
        end else begin
            latin1_mode_reg <= latin1_mode_next;
        end
    end

    u2l_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .latin1_mode (latin1_mode_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_cmd  (q_push_cmd)
    );

    u2l_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    u2l_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_head_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_in_run (m_last_in_run)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the utf-8 text sanitizer
// Streams directed and random utf-8 byte sequences through the block in both
// output modes, with bursty input and a stalling receiver, and checks every
// output byte and its end-of-run flag against a built-in sanitizer model.
// ----------------------------------------------------------------------------
module testbench;
    import u2l_pkg::*;

    localparam logic MODE_UTF8   = 1'b0;
    localparam logic MODE_LATIN1 = 1'b1;

    localparam int PHASE_ITEMS = 108;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_latin1_mode = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_in_run;

    // bytes waiting to be sent and sanitized text still to come
    logic [7:0] input_text_q[$];
    text_byte_t clean_text_q[$];
    logic [7:0] run_bytes[$];

    // sanitizer model state
    logic        mode_latin1;
    logic [20:0] partial_cp;
    logic [1:0]  cont_left;
    logic        saw_cr;

    logic        s_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] ready_pat = 16'hffff;
    int          pat_step = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    utf8_to_latin1_text_sanitizer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_latin1_mode (cfg_latin1_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_in_run   (m_last_in_run)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch in %s: got %02h, expected %02h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + nib : 8'h61 + (nib - 4'd10);
    endfunction

    // filter one decoded code point and write it in the current mode
    task automatic emit_code_point(input logic [20:0] cp);
        logic [31:0] cpx;
        cpx = {11'd0, cp};
        if (!((cp < 21'h20 && cp != 21'h09 && cp != 21'h0A) ||
              (cp >= 21'h7F && cp < 21'hA0))) begin
            if (mode_latin1) begin
                if (cp <= 21'hFF) begin
                    run_bytes.push_back(cp[7:0]);
                end else if (cp < 21'h10000) begin
                    run_bytes.push_back(BYTE_BACKSLASH);
                    run_bytes.push_back(BYTE_LOWER_U);
                    for (int i = 3; i >= 0; i--)
                        run_bytes.push_back(hex_digit(cpx[4*i +: 4]));
                end else begin
                    run_bytes.push_back(BYTE_BACKSLASH);
                    run_bytes.push_back(BYTE_UPPER_U);
                    for (int i = 7; i >= 0; i--)
                        run_bytes.push_back(hex_digit(cpx[4*i +: 4]));
                end
            end else begin
                if (cp < 21'h80) begin
                    run_bytes.push_back(cp[7:0]);
                end else if (cp < 21'h800) begin
                    run_bytes.push_back({3'b110, cp[10:6]});
                    run_bytes.push_back({2'b10, cp[5:0]});
                end else if (cp < 21'h10000) begin
                    run_bytes.push_back({4'b1110, cp[15:12]});
                    run_bytes.push_back({2'b10, cp[11:6]});
                    run_bytes.push_back({2'b10, cp[5:0]});
                end else begin
                    run_bytes.push_back({5'b11110, cp[20:18]});
                    run_bytes.push_back({2'b10, cp[17:12]});
                    run_bytes.push_back({2'b10, cp[11:6]});
                    run_bytes.push_back({2'b10, cp[5:0]});
                end
            end
        end
    endtask

    // decode one input byte and queue the bytes it should produce
    task automatic sanitize_byte(input logic [7:0] b);
        logic was_cr;
        text_byte_t tb;
        was_cr = saw_cr;
        saw_cr = 1'b0;
        run_bytes = {};
        if (b >= 8'h80 && b <= 8'hBF) begin
            // continuation, ignored when no sequence is open
            if (cont_left != 2'd0) begin
                partial_cp = {partial_cp[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    emit_code_point(partial_cp);
                    partial_cp = '0;
                end
            end
        end else begin
            cont_left  = 2'd0;
            partial_cp = '0;
            if (b == BYTE_CR) begin
                run_bytes.push_back(BYTE_LF);
                saw_cr = 1'b1;
            end else if (b == BYTE_LF && was_cr) begin
                // lf of a cr lf pair goes away
            end else if (b < 8'h80) begin
                emit_code_point({13'd0, b});
            end else if (b <= 8'hDF) begin
                partial_cp = {16'd0, b[4:0]};
                cont_left  = 2'd1;
            end else if (b <= 8'hEF) begin
                partial_cp = {17'd0, b[3:0]};
                cont_left  = 2'd2;
            end else if (b <= 8'hF7) begin
                partial_cp = {18'd0, b[2:0]};
                cont_left  = 2'd3;
            end
        end
        foreach (run_bytes[i]) begin
            tb.data = run_bytes[i];
            tb.last = (i == run_bytes.size() - 1);
            clean_text_q.push_back(tb);
        end
    endtask

    // handshakes, model update and output check
    always @(posedge aclk) begin
        text_byte_t want;
        if (!aresetn) begin
            mode_latin1 = MODE_LATIN1;
            partial_cp  = '0;
            cont_left   = 2'd0;
            saw_cr      = 1'b0;
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                mode_latin1 = cfg_latin1_mode;
            if (s_valid && s_ready)
                sanitize_byte(s_in_byte);
            if (m_valid && m_ready) begin
                if (clean_text_q.size() == 0) begin
                    report_mismatch("unexpected output byte", m_out_byte, 8'h00);
                end else begin
                    want = clean_text_q.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch("out_byte", m_out_byte, want.data);
                    if (m_last_in_run !== want.last)
                        report_mismatch("last_in_run", {7'd0, m_last_in_run},
                                        {7'd0, want.last});
                end
            end
        end
    end

    // input driver: bursts of items with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (input_text_q.size() != 0) begin
                s_valid   <= 1'b1;
                s_in_byte <= input_text_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, regularly reloaded with a new random one
    always @(negedge aclk) begin
        m_ready  <= ready_pat[0];
        pat_step <= pat_step + 1;
        if (pat_step % 16 == 15) begin
            if ($urandom_range(0, 3) == 0)
                ready_pat <= 16'hffff;
            else
                ready_pat <= 16'($urandom) | 16'h0001;
        end else begin
            ready_pat <= {ready_pat[0], ready_pat[15:1]};
        end
    end

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // append one random sequence, mostly well formed; returns its length
    function automatic int add_random_sequence();
        int pick;
        int len;
        int keep;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        len  = input_text_q.size();
        if (pick < 25) begin
            input_text_q.push_back(8'($urandom_range(0, 127)));
        end else if (pick < 32) begin
            input_text_q.push_back(BYTE_CR);
            if ($urandom_range(0, 1) == 1)
                input_text_q.push_back(BYTE_LF);
        end else if (pick < 47) begin
            input_text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            input_text_q.push_back(cont_byte());
        end else if (pick < 62) begin
            input_text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) input_text_q.push_back(cont_byte());
        end else if (pick < 77) begin
            input_text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) input_text_q.push_back(cont_byte());
        end else if (pick < 87) begin
            // sequence cut short by a new byte
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            keep = (lead >= 8'hF0) ? 2 : (lead >= 8'hE0) ? 1 : 0;
            input_text_q.push_back(lead);
            repeat ($urandom_range(0, keep)) input_text_q.push_back(cont_byte());
            if ($urandom_range(0, 3) == 0)
                input_text_q.push_back(BYTE_CR);
            else
                input_text_q.push_back(8'($urandom_range(0, 127)));
        end else begin
            input_text_q.push_back(8'($urandom_range(0, 255)));
        end
        return input_text_q.size() - len;
    endfunction

    // wait until the block has drained everything sent so far
    task automatic wait_drained();
        while (input_text_q.size() != 0 || s_valid || clean_text_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_latin1_mode <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus and end of run
    initial begin
        int sent;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed text in latin-1 mode after reset
        input_text_q = {8'h00, 8'h09, 8'h0D, 8'h0A, 8'h0A, 8'h7F, 8'h20,
                        8'hC2, 8'hA0, 8'hC4, 8'h80,
                        8'hF7, 8'hBF, 8'hBF, 8'hBF,
                        8'hBF, 8'hF8, 8'hFF,
                        8'hE2, 8'h41,
                        8'hC3, 8'h0D, 8'h0A,
                        8'hC0, 8'h80};
        wait_drained();

        // random text, alternating output modes
        for (int phase = 0; phase < 4; phase++) begin
            write_mode((phase % 2 == 0) ? MODE_UTF8 : MODE_LATIN1);
            sent = 0;
            while (sent < PHASE_ITEMS)
                sent += add_random_sequence();
            wait_drained();
        end

        if (error_count == 0 && clean_text_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
